[rtl/idq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// idq_pkg
// Shared constants, request and status codes, and ring arithmetic for the
// indexed double-ended queue.
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int DEPTH        = 16;
    localparam int HANDLE_WIDTH = 32;

    // Fixed field widths of the request and result items.
    localparam int REQ_W  = 3;
    localparam int ELEM_W = 32;
    localparam int IDX_W  = 17;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Stream packing widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((ELEM_W + 2 * IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ELEM_W + LEN_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_TAIL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RANGE     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_WRITE     = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // Slot of the element at position off from the head, modulo DEPTH.
    function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] front,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(front) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/idq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// idq_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Read data holds until the next read is issued.
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/indexed_double_ended_queue_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_double_ended_queue_top
// Bounded deque of element handles in a ring RAM, with push and pop at both
// ends, indexed read and overwrite, and range readout.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in idle, decoded in the decode state, and its
// result is loaded into the output register; pop and read results first pass
// through the registered read port of the ring RAM. A new request is taken only
// once the previous one has finished; a range of k elements streams one element
// per cycle while the output is not stalled.
// Reset: rst_n clears the head pointer, the count and all control state at
// once; the RAM contents stay undefined until pushed or overwritten.
// ----------------------------------------------------------------------------
module indexed_double_ended_queue_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Request side.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata fields from bit 0: value[31:0], start_index[48:32],
    // stop_index[65:49], zero fill up to bit 71.
    input  wire logic [idq_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0: req_type[2:0].
    input  wire logic [idq_pkg::REQ_W-1:0]       s_tuser,
    // Result side.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata fields from bit 0: element[31:0], length[36:32], zero fill
    // up to bit 39.
    output logic      [idq_pkg::M_DATA_W-1:0]    m_tdata,
    // m_tuser fields from bit 0: status[1:0].
    output logic      [idq_pkg::STAT_W-1:0]      m_tuser,
    output logic                                 m_tlast
);

    import idq_pkg::*;

    // Controller states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_HOLD   = 2'd2;
    localparam logic [1:0] S_RANGE  = 2'd3;

    logic [1:0]                state_reg, state_next;

    // Latched request.
    logic [REQ_W-1:0]          req_reg;
    logic [ELEM_W-1:0]         val_reg;
    logic signed [IDX_W-1:0]   a_reg;
    logic signed [IDX_W-1:0]   b_reg;

    // Queue state.
    logic [POS_W-1:0]          front_reg, front_next;
    logic [CNT_W-1:0]          count_reg, count_next;

    // Range walk positions and the result held while the output is busy.
    logic [POS_W-1:0]          cur_reg, cur_next;
    logic [POS_W-1:0]          stop_reg, stop_next;
    logic [STAT_W-1:0]         res_status_reg, res_status_next;
    logic                      res_use_rd_reg, res_use_rd_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]         out_status_reg;
    logic [ELEM_W-1:0]         out_elem_reg;
    logic [LEN_W-1:0]          out_len_reg;
    logic                      out_last_reg;

    logic                      out_free;
    logic                      out_load;
    logic [STAT_W-1:0]         load_status;
    logic [ELEM_W-1:0]         load_elem;
    logic                      load_last;

    // RAM port signals.
    logic                      ram_we;
    logic [POS_W-1:0]          ram_waddr;
    logic                      ram_re;
    logic [POS_W-1:0]          ram_raddr;
    logic [HANDLE_WIDTH-1:0]   ram_rdata;

    // Index resolution.
    logic signed [IDX_W:0]     n_ext;
    logic signed [IDX_W:0]     a_ext, b_ext;
    logic signed [IDX_W:0]     a_adj, b_adj;
    logic signed [IDX_W:0]     a_clip, b_clip;
    logic                      idx_ok;
    logic                      range_empty;

    logic [STAT_W-1:0]         dec_status;
    logic                      dec_read;
    logic                      dec_range;

    // The only write happens in the decode state and a request that writes does
    // not read; a later request reads only after passing through idle and its
    // own decode, so no forwarding path is needed.
    idq_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (HANDLE_WIDTH'(val_reg)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A negative index counts back from the tail: add the count first.
    assign n_ext  = $signed({{(IDX_W + 1 - CNT_W){1'b0}}, count_reg});
    assign a_ext  = $signed({a_reg[IDX_W-1], a_reg});
    assign b_ext  = $signed({b_reg[IDX_W-1], b_reg});
    assign a_adj  = a_reg[IDX_W-1] ? a_ext + n_ext : a_ext;
    assign b_adj  = b_reg[IDX_W-1] ? b_ext + n_ext : b_ext;
    assign idx_ok = !a_adj[IDX_W] && (a_adj < n_ext);

    // Range bounds are clipped to the stored elements.
    assign a_clip = a_adj[IDX_W] ? '0 : a_adj;
    assign b_clip = (b_adj >= n_ext) ? n_ext - (IDX_W + 1)'(1) : b_adj;
    assign range_empty = (count_reg == '0) || (a_clip > b_clip);

    // The output register can take a new result when empty or draining.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        stop_next       = stop_reg;
        res_status_next = res_status_reg;
        res_use_rd_next = res_use_rd_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        out_load        = 1'b0;
        load_status     = ST_OK;
        load_elem       = '0;
        load_last       = 1'b1;
        dec_status      = ST_OK;
        dec_read        = 1'b0;
        dec_range       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (req_reg)
                    REQ_PUSH_HEAD, REQ_PUSH_TAIL:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            dec_status = ST_FULL;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            if (req_reg == REQ_PUSH_HEAD)
                            begin
                                front_next = (front_reg == '0) ?
                                             POS_W'(DEPTH - 1) : front_reg - POS_W'(1);
                                ram_waddr  = front_next;
                            end
                            else
                            begin
                                ram_waddr = wrap_add(front_reg, count_reg);
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                    end

                    REQ_POP_HEAD, REQ_POP_TAIL:
                    begin
                        if (count_reg == '0)
                        begin
                            dec_status = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re   = 1'b1;
                            dec_read = 1'b1;
                            if (req_reg == REQ_POP_HEAD)
                            begin
                                ram_raddr  = front_reg;
                                front_next = (front_reg == POS_W'(DEPTH - 1)) ?
                                             '0 : front_reg + POS_W'(1);
                            end
                            else
                            begin
                                ram_raddr = wrap_add(front_reg, count_reg - CNT_W'(1));
                            end
                            count_next = count_reg - CNT_W'(1);
                        end
                    end

                    REQ_RANGE:
                    begin
                        if (range_empty)
                        begin
                            dec_status = ST_EMPTY;
                        end
                        else
                        begin
                            cur_next  = a_clip[POS_W-1:0];
                            stop_next = b_clip[POS_W-1:0];
                            ram_re    = 1'b1;
                            ram_raddr = wrap_add(front_reg, CNT_W'(a_clip[POS_W-1:0]));
                            dec_range = 1'b1;
                        end
                    end

                    REQ_READ:
                    begin
                        if (!idx_ok)
                        begin
                            dec_status = ST_RANGE;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = wrap_add(front_reg, CNT_W'(a_adj[POS_W-1:0]));
                            dec_read  = 1'b1;
                        end
                    end

                    REQ_WRITE:
                    begin
                        if (!idx_ok)
                        begin
                            dec_status = ST_RANGE;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = wrap_add(front_reg, CNT_W'(a_adj[POS_W-1:0]));
                        end
                    end

                    default:
                    begin
                        dec_status = ST_OK;
                    end
                endcase

                if (dec_range)
                begin
                    state_next = S_RANGE;
                end
                else if (dec_read)
                begin
                    res_status_next = dec_status;
                    res_use_rd_next = 1'b1;
                    state_next      = S_HOLD;
                end
                else if (out_free)
                begin
                    out_load    = 1'b1;
                    load_status = dec_status;
                    state_next  = S_IDLE;
                end
                else
                begin
                    res_status_next = dec_status;
                    res_use_rd_next = 1'b0;
                    state_next      = S_HOLD;
                end
            end

            S_HOLD:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_status = res_status_reg;
                    load_elem   = res_use_rd_reg ? ELEM_W'(ram_rdata) : '0;
                    state_next  = S_IDLE;
                end
            end

            S_RANGE:
            begin
                // Each accepted element launches the read of the next one.
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_elem   = ELEM_W'(ram_rdata);
                    load_last   = (cur_reg == stop_reg);
                    if (cur_reg == stop_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next  = cur_reg + POS_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = wrap_add(front_reg, CNT_W'(cur_reg) + CNT_W'(1));
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_use_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            res_status_reg <= res_status_next;
            res_use_rd_reg <= res_use_rd_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        stop_reg <= stop_next;
        if (s_tvalid && s_tready)
        begin
            req_reg <= s_tuser;
            val_reg <= s_tdata[ELEM_W-1:0];
            a_reg   <= s_tdata[ELEM_W +: IDX_W];
            b_reg   <= s_tdata[ELEM_W + IDX_W +: IDX_W];
        end
        if (out_load)
        begin
            out_status_reg <= load_status;
            out_elem_reg   <= load_elem;
            out_len_reg    <= LEN_W'(count_next);
            out_last_reg   <= load_last;
        end
    end

    // A new request is taken only between requests; a finished result may
    // still be waiting in the output register.
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - ELEM_W - LEN_W){1'b0}}, out_len_reg, out_elem_reg};

`ifndef NO_ASSERTIONS
    // The count never exceeds the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond ring depth");

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // An accepted request is decoded in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    // A range walk never passes its clipped stop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RANGE) |-> (cur_reg <= stop_reg && stop_reg < count_reg[POS_W-1:0]
                                    || cur_reg <= stop_reg && count_reg == CNT_W'(DEPTH)))
        else $error("range walk out of bounds");

    // The head pointer stays inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(front_reg) < CNT_W'(DEPTH))
        else $error("head pointer outside ring");
`endif

endmodule
`default_nettype wire
